/* rtl/core/uniform_lbp_3x3_coder_defines.svh */
// ----------------------------------------------------------------------------
// uniform_lbp_3x3_coder_defines
// Assertion macros shared by the uniform LBP coder RTL.
// ----------------------------------------------------------------------------
`ifndef UNIFORM_LBP_3X3_CODER_DEFINES_SVH
`define UNIFORM_LBP_3X3_CODER_DEFINES_SVH

`ifndef ASSERT_OFF

`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`else

`define ASSERT_SAME(label, clk, rst, ante, cons)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/ulbp_pkg.sv */
// ----------------------------------------------------------------------------
// ulbp_pkg
// Widths, register indexes, reset values and the 59-bin uniform code table.
// ----------------------------------------------------------------------------
`default_nettype none

package ulbp_pkg;

   localparam int PIXEL_W    = 8;
   localparam int CODE_W     = 6;
   localparam int WIDTH_W    = 11;
   localparam int HEIGHT_W   = 16;
   localparam int CSR_DATA_W = 16;

   typedef logic [PIXEL_W-1:0]  pixel_type;
   typedef logic [CODE_W-1:0]   code_type;
   typedef logic [WIDTH_W-1:0]  width_type;
   typedef logic [HEIGHT_W-1:0] height_type;

   typedef enum logic {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   localparam width_type  IMAGE_WIDTH_RESET  = width_type'(640);
   localparam height_type IMAGE_HEIGHT_RESET = height_type'(480);

   typedef code_type bin_table_type [256];

   function automatic bin_table_type build_bin_table();
      bin_table_type tbl;
      logic [7:0]    pat;
      logic [7:0]    rot;
      int unsigned   nxt;
      int unsigned   cnt;
      nxt = 1;
      for (int p = 0; p < 256; p++) begin
         pat = 8'(p);
         rot = {pat[6:0], pat[7]};
         cnt = $countones(pat ^ rot);
         if (cnt <= 2) begin
            tbl[p] = code_type'(nxt);
            nxt++;
         end else begin
            tbl[p] = '0;
         end
      end
      return tbl;
   endfunction

   localparam bin_table_type BIN_TABLE = build_bin_table();

endpackage

`default_nettype wire

/* rtl/core/uniform_lbp_3x3_coder.sv */
// ----------------------------------------------------------------------------
// uniform_lbp_3x3_coder
// Streaming 3x3 uniform LBP coder: line store, window, 59-bin code lookup.
//
//   channel  ports                          direction  handshake
//   req      req_pixel                      in         req_valid / req_ready
//   rsp      rsp_code, rsp_frame_last       out        rsp_valid / rsp_ready
//   csr      csr_index, csr_wr_data         in         csr_wr_en, no wait
//
// One pixel per clock when rsp is not stalled by rsp_ready; a code passes stage
// A, the window and the output register. Stages: line store read, window shift
// and store write, compare and lookup. The single line store holds both
// previous rows per column, 16 bits. req_ready drops only while a result sits
// in the output register unread. Synchronous reset clears counters, window and
// pipeline valids; the line store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "uniform_lbp_3x3_coder_defines.svh"

module uniform_lbp_3x3_coder
   import ulbp_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic [PIXEL_W-1:0]    req_pixel,

   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic [CODE_W-1:0]     rsp_code,
   output      logic                  rsp_frame_last,

   input  wire logic                  csr_wr_en,
   input  wire logic                  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int EXT_W = (WIDTH_W > COL_W + 1) ? WIDTH_W : COL_W + 1;

   typedef logic [COL_W-1:0] col_type;
   typedef logic [EXT_W-1:0] ext_type;

   // configuration
   width_type  image_width_ff;
   height_type image_height_ff;

   // position counters
   col_type    col_ff, col_in;
   height_type row_ff, row_in;

   // line store: {upper, middle} per column
   logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];

   // stage A
   logic                 a_valid_ff;
   logic                 a_emit_ff;
   logic                 a_last_ff;
   col_type              a_col_ff;
   pixel_type            a_pixel_ff;
   logic [2*PIXEL_W-1:0] rd_ff;
   logic                 byp_ff;
   logic [2*PIXEL_W-1:0] byp_data_ff;

   // stage B
   logic      b_valid_ff;
   logic      b_last_ff;
   pixel_type win_ff [3][3];

   // output
   logic     rsp_valid_ff;
   code_type rsp_code_ff;
   logic     rsp_last_ff;

   logic                 adv;
   logic                 accept;
   ext_type              width_ext;
   ext_type              max_ext;
   ext_type              w_eff;
   ext_type              col_inc;
   logic                 col_wrap;
   logic [HEIGHT_W:0]    row_inc;
   logic                 row_wrap;
   logic                 emit;
   logic                 last;
   logic [2*PIXEL_W-1:0] pair;
   pixel_type            ctr;
   logic [7:0]           pattern;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign accept    = req_valid && adv;

   // ---------------------------------------------------------------- counters
   always_comb begin
      width_ext = ext_type'(image_width_ff);
      max_ext   = ext_type'(MAX_WIDTH);
      w_eff     = (width_ext > max_ext) ? max_ext : width_ext;
      col_inc   = ext_type'(col_ff) + ext_type'(1);
      col_wrap  = col_inc >= w_eff;
      row_inc   = {1'b0, row_ff} + {{HEIGHT_W{1'b0}}, 1'b1};
      row_wrap  = row_inc >= {1'b0, image_height_ff};
      emit      = (row_ff >= height_type'(2)) && (col_ff >= col_type'(2));
      last      = emit && (col_inc == w_eff) && (row_inc == {1'b0, image_height_ff});

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (col_wrap) begin
            col_in = '0;
            row_in = row_wrap ? '0 : row_inc[HEIGHT_W-1:0];
         end else begin
            col_in = col_inc[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= IMAGE_WIDTH_RESET;
         image_height_ff <= IMAGE_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wr_data[WIDTH_W-1:0];
               CSR_IMAGE_HEIGHT: image_height_ff <= csr_wr_data[HEIGHT_W-1:0];
               default:          image_width_ff  <= image_width_ff;
            endcase
         end
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- stage A
   assign pair = byp_ff ? byp_data_ff : rd_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rd_ff <= line_mem[col_ff];
      end
      if (adv && a_valid_ff) begin
         line_mem[a_col_ff] <= {pair[PIXEL_W-1:0], a_pixel_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         byp_ff     <= 1'b0;
      end else if (adv) begin
         a_valid_ff <= req_valid;
         if (req_valid) begin
            byp_ff <= a_valid_ff && (a_col_ff == col_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         a_emit_ff   <= emit;
         a_last_ff   <= last;
         a_col_ff    <= col_ff;
         a_pixel_ff  <= req_pixel;
         byp_data_ff <= {pair[PIXEL_W-1:0], a_pixel_ff};
      end
   end

   // ---------------------------------------------------------------- stage B
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_last_ff  <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (adv) begin
         b_valid_ff <= a_valid_ff && a_emit_ff;
         b_last_ff  <= a_last_ff;
         if (a_valid_ff) begin
            for (int i = 0; i < 3; i++) begin
               win_ff[i][0] <= win_ff[i][1];
               win_ff[i][1] <= win_ff[i][2];
            end
            win_ff[0][2] <= pair[2*PIXEL_W-1:PIXEL_W];
            win_ff[1][2] <= pair[PIXEL_W-1:0];
            win_ff[2][2] <= a_pixel_ff;
         end
      end
   end

   // ---------------------------------------------------------------- stage C
   always_comb begin
      ctr        = win_ff[1][1];
      pattern[7] = win_ff[0][0] >= ctr;
      pattern[6] = win_ff[0][1] >= ctr;
      pattern[5] = win_ff[0][2] >= ctr;
      pattern[4] = win_ff[1][2] >= ctr;
      pattern[3] = win_ff[2][2] >= ctr;
      pattern[2] = win_ff[2][1] >= ctr;
      pattern[1] = win_ff[2][0] >= ctr;
      pattern[0] = win_ff[1][0] >= ctr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_code_ff <= BIN_TABLE[pattern];
         rsp_last_ff <= b_last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code       = rsp_code_ff;
   assign rsp_frame_last = rsp_last_ff;

   // ---------------------------------------------------------------- checks
   `ASSERT_NEXT(col_wrap_chk, clock, reset, accept && col_wrap, col_ff == '0)
   `ASSERT_NEXT(col_step_chk, clock, reset, accept && !col_wrap, col_ff == $past(col_inc[COL_W-1:0]))
   `ASSERT_NEXT(a_hold_chk, clock, reset, !adv, a_valid_ff == $past(a_valid_ff))
   `ASSERT_NEXT(b_hold_chk, clock, reset, !adv, b_valid_ff == $past(b_valid_ff))

endmodule

`default_nettype wire
